/* hdl/four_motor_split_direction_stepper_defines.svh */
// Assertion macros shared by the RTL of the split-direction stepper.
`ifndef FOUR_MOTOR_SPLIT_DIRECTION_STEPPER_DEFINES_SVH
`define FOUR_MOTOR_SPLIT_DIRECTION_STEPPER_DEFINES_SVH

`ifndef ASSERT_OFF
// Check that holds outside reset.
`define FMSDS_ASSERT(label, clock, reset, prop) \
  label: assert property (@(posedge clock) disable iff (reset) prop) \
    else $error("fmsds assertion failed");
// Check that holds at every edge, reset included.
`define FMSDS_ASSERT_ALWAYS(label, clock, prop) \
  label: assert property (@(posedge clock) prop) \
    else $error("fmsds assertion failed");
`else
`define FMSDS_ASSERT(label, clock, reset, prop)
`define FMSDS_ASSERT_ALWAYS(label, clock, prop)
`endif

`endif

/* hdl/fmsds_pkg.sv */
// Constants and types shared by the split-direction stepper modules.
`default_nettype none

package fmsds_pkg;

  // Sizing
  localparam int MOTOR_COUNT     = 4;
  localparam int STEP_COUNT_BITS = 16;
  localparam int DEV_FIELDS      = 4;
  localparam int DEV_WIDTH       = 20;
  localparam int SPM_WIDTH       = 20;
  localparam int ENABLE_OUT_BITS = 4;

  // Count = (|dev| * step_rate + half) >> ROUND_SHIFT
  localparam int PROD_WIDTH  = DEV_WIDTH + SPM_WIDTH;
  localparam int ROUND_SHIFT = 24;
  localparam int RAW_WIDTH   = PROD_WIDTH + 1 - ROUND_SHIFT;
  localparam logic [PROD_WIDTH:0] ROUND_HALF = (PROD_WIDTH + 1)'(1) << (ROUND_SHIFT - 1);

  localparam logic [SPM_WIDTH-1:0] SPM_RESET = SPM_WIDTH'(102400);

  // Operation codes
  localparam logic OP_START = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  typedef logic [STEP_COUNT_BITS-1:0] count_t;

  // One item as seen by the sequencer: op plus per-motor count and direction
  typedef struct packed {
    logic                          op;
    logic [MOTOR_COUNT-1:0]        up;
    count_t [MOTOR_COUNT-1:0]      count;
  } seq_item_t;

  // Sequencer state seen at the result port
  typedef struct packed {
    logic                   step_level;
    logic                   direction_up;
    logic [MOTOR_COUNT-1:0] motor_enables;
    logic                   shared_enable;
    logic                   busy;
    logic                   ignored;
  } seq_status_t;

endpackage

`default_nettype wire

/* hdl/fmsds_seq.sv */
// Group sequencer: holds the move state and applies one item per cycle while apply is high.
`default_nettype none

module fmsds_seq (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 apply,
  input  wire fmsds_pkg::seq_item_t item,
  output fmsds_pkg::seq_status_t    status
);

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_UP   = 2'd1,
    PH_DOWN = 2'd2
  } phase_t;

  // Longest count among the motors selected by mask
  function automatic fmsds_pkg::count_t longest_of(
    input fmsds_pkg::count_t [fmsds_pkg::MOTOR_COUNT-1:0] counts,
    input logic [fmsds_pkg::MOTOR_COUNT-1:0]              mask
  );
    fmsds_pkg::count_t best;
    best = '0;
    for (int i = 0; i < fmsds_pkg::MOTOR_COUNT; i++) begin
      if (mask[i] && counts[i] > best) begin
        best = counts[i];
      end
    end
    return best;
  endfunction

  fmsds_pkg::count_t [fmsds_pkg::MOTOR_COUNT-1:0] motor_step_total, motor_step_total_next;
  logic [fmsds_pkg::MOTOR_COUNT-1:0] motor_goes_up, motor_goes_up_next;
  phase_t                            group_phase, group_phase_next;
  fmsds_pkg::count_t                 step_index, step_index_next;
  fmsds_pkg::count_t                 group_longest, group_longest_next;
  logic                              pulse_high, pulse_high_next;
  logic [fmsds_pkg::MOTOR_COUNT-1:0] enable_mask, enable_mask_next;
  logic                              common_enable, common_enable_next;
  logic                              dir_line, dir_line_next;
  logic                              ignored, ignored_next;

  logic                              busy;
  logic [fmsds_pkg::MOTOR_COUNT-1:0] in_nonzero, in_up_mask, in_down_mask;
  logic [fmsds_pkg::MOTOR_COUNT-1:0] st_nonzero, st_down_mask, hit_mask;
  fmsds_pkg::count_t                 in_up_longest, in_down_longest, st_down_longest;
  fmsds_pkg::count_t                 index_inc;

  assign busy = (group_phase == PH_UP) || (group_phase == PH_DOWN);

  // Group masks for an incoming start and for the stored down group
  always_comb begin
    for (int i = 0; i < fmsds_pkg::MOTOR_COUNT; i++) begin
      in_nonzero[i] = (item.count[i] != '0);
      st_nonzero[i] = (motor_step_total[i] != '0);
      hit_mask[i]   = (motor_step_total[i] == step_index);
    end
  end

  assign in_up_mask      = in_nonzero & item.up;
  assign in_down_mask    = in_nonzero & ~item.up;
  assign st_down_mask    = st_nonzero & ~motor_goes_up;
  assign in_up_longest   = longest_of(item.count, in_up_mask);
  assign in_down_longest = longest_of(item.count, in_down_mask);
  assign st_down_longest = longest_of(motor_step_total, st_down_mask);
  assign index_inc       = step_index + fmsds_pkg::STEP_COUNT_BITS'(1);

  // Next state for the item being applied
  always_comb begin
    motor_step_total_next = motor_step_total;
    motor_goes_up_next    = motor_goes_up;
    group_phase_next      = group_phase;
    step_index_next       = step_index;
    group_longest_next    = group_longest;
    pulse_high_next       = pulse_high;
    enable_mask_next      = enable_mask;
    common_enable_next    = common_enable;
    dir_line_next         = dir_line;
    ignored_next          = ignored;
    if (apply) begin
      ignored_next = 1'b0;
      if (item.op == fmsds_pkg::OP_START) begin
        if (busy) begin
          ignored_next = 1'b1;
        end else begin
          motor_step_total_next = item.count;
          motor_goes_up_next    = item.up;
          if (|in_nonzero) begin
            common_enable_next = 1'b0;
            step_index_next    = '0;
            pulse_high_next    = 1'b0;
            if (in_up_longest != '0) begin
              enable_mask_next   = in_up_mask;
              group_longest_next = in_up_longest;
              dir_line_next      = 1'b1;
              group_phase_next   = PH_UP;
            end else begin
              enable_mask_next   = in_down_mask;
              group_longest_next = in_down_longest;
              dir_line_next      = 1'b0;
              group_phase_next   = PH_DOWN;
            end
          end
        end
      end else begin
        case (group_phase)
          PH_UP, PH_DOWN: begin
            if (!pulse_high) begin
              // rising edge: drop motors that have finished their count
              enable_mask_next = enable_mask & ~hit_mask;
              pulse_high_next  = 1'b1;
            end else begin
              pulse_high_next = 1'b0;
              if (index_inc < group_longest) begin
                step_index_next = index_inc;
              end else if (group_phase == PH_UP && st_down_longest != '0) begin
                // up group done, down group follows in the same tick
                enable_mask_next   = st_down_mask;
                group_longest_next = st_down_longest;
                step_index_next    = '0;
                dir_line_next      = 1'b0;
                group_phase_next   = PH_DOWN;
              end else begin
                enable_mask_next   = '0;
                step_index_next    = '0;
                group_longest_next = '0;
                common_enable_next = 1'b1;
                group_phase_next   = PH_IDLE;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // State registers; they double as the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      motor_step_total <= '0;
      motor_goes_up    <= '0;
      group_phase      <= PH_IDLE;
      step_index       <= '0;
      group_longest    <= '0;
      pulse_high       <= 1'b0;
      enable_mask      <= '0;
      common_enable    <= 1'b1;
      dir_line         <= 1'b0;
      ignored          <= 1'b0;
    end else begin
      motor_step_total <= motor_step_total_next;
      motor_goes_up    <= motor_goes_up_next;
      group_phase      <= group_phase_next;
      step_index       <= step_index_next;
      group_longest    <= group_longest_next;
      pulse_high       <= pulse_high_next;
      enable_mask      <= enable_mask_next;
      common_enable    <= common_enable_next;
      dir_line         <= dir_line_next;
      ignored          <= ignored_next;
    end
  end

  assign status.step_level    = pulse_high;
  assign status.direction_up  = dir_line;
  assign status.motor_enables = enable_mask;
  assign status.shared_enable = common_enable;
  assign status.busy          = busy;
  assign status.ignored       = ignored;

endmodule

`default_nettype wire

/* hdl/four_motor_split_direction_stepper.sv */
// Top level of the four-motor split-direction stepper sequencer.
//
// Accepts one beat per clock while in_stall is low and returns one result beat
// per input beat, through registered stages: an input register, a stage that
// holds each motor's rounded step count (one 20x20 multiplier per motor), and
// the sequencer state, which is also the result register. A start converts the
// four deviations to counts and opens the upward group, or the downward group
// if no motor moves up; each tick is one half step period. The step rate
// register may be written only while no beat is in flight.
`default_nettype none

`include "four_motor_split_direction_stepper_defines.svh"

module four_motor_split_direction_stepper (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // configuration
  input  wire logic                                  cfg_write_enable,
  input  wire logic [fmsds_pkg::SPM_WIDTH-1:0]       cfg_write_data,
  // input channel
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic                                  operation,
  input  wire logic signed [fmsds_pkg::DEV_WIDTH-1:0] deviation_a,
  input  wire logic signed [fmsds_pkg::DEV_WIDTH-1:0] deviation_b,
  input  wire logic signed [fmsds_pkg::DEV_WIDTH-1:0] deviation_c,
  input  wire logic signed [fmsds_pkg::DEV_WIDTH-1:0] deviation_d,
  // output channel
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic                                       step_level,
  output logic                                       direction_up,
  output logic [fmsds_pkg::ENABLE_OUT_BITS-1:0]      motor_enables,
  output logic                                       shared_enable,
  output logic                                       busy_res,
  output logic                                       command_ignored
);

  logic [fmsds_pkg::SPM_WIDTH-1:0] step_rate;

  // stage 1: input register
  logic                                                  s1_valid;
  logic                                                  s1_op;
  logic [fmsds_pkg::DEV_FIELDS-1:0][fmsds_pkg::DEV_WIDTH-1:0] s1_dev;

  // stage 2: counts
  logic                  s2_valid;
  fmsds_pkg::seq_item_t  s2_item;
  fmsds_pkg::seq_item_t  s2_item_next;

  logic adv2, adv1, out_free, s2_free, s1_free, in_take;
  fmsds_pkg::seq_status_t status;

  // Flow control across the three stages
  assign out_free = !out_valid || !out_stall;
  assign adv2     = s2_valid && out_free;
  assign s2_free  = !s2_valid || adv2;
  assign adv1     = s1_valid && s2_free;
  assign s1_free  = !s1_valid || adv1;
  assign in_stall = !s1_free;
  assign in_take  = in_valid && s1_free;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      step_rate <= fmsds_pkg::SPM_RESET;
    end else if (cfg_write_enable) begin
      step_rate <= cfg_write_data;
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= in_take || (s1_valid && !adv1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_op     <= operation;
      s1_dev[0] <= deviation_a;
      s1_dev[1] <= deviation_b;
      s1_dev[2] <= deviation_c;
      s1_dev[3] <= deviation_d;
    end
  end

  // Per-motor count: magnitude, multiply, round, saturate
  assign s2_item_next.op = s1_op;

  for (genvar i = 0; i < fmsds_pkg::MOTOR_COUNT; i++) begin : g_lane
    logic [fmsds_pkg::DEV_WIDTH-1:0]  dev;
    logic [fmsds_pkg::DEV_WIDTH-1:0]  mag;
    logic [fmsds_pkg::PROD_WIDTH-1:0] prod;
    logic [fmsds_pkg::PROD_WIDTH:0]   rounded;
    logic [fmsds_pkg::RAW_WIDTH-1:0]  raw;

    if (i < fmsds_pkg::DEV_FIELDS) begin : g_dev
      assign dev = s1_dev[i];
    end else begin : g_zero
      assign dev = '0;
    end

    assign mag     = dev[fmsds_pkg::DEV_WIDTH-1] ? (~dev + fmsds_pkg::DEV_WIDTH'(1)) : dev;
    assign prod    = fmsds_pkg::PROD_WIDTH'(mag) * fmsds_pkg::PROD_WIDTH'(step_rate);
    assign rounded = (fmsds_pkg::PROD_WIDTH + 1)'(prod) + fmsds_pkg::ROUND_HALF;
    assign raw     = rounded[fmsds_pkg::PROD_WIDTH:fmsds_pkg::ROUND_SHIFT];

    assign s2_item_next.up[i] = !dev[fmsds_pkg::DEV_WIDTH-1] && (dev != '0);

    if (fmsds_pkg::RAW_WIDTH > fmsds_pkg::STEP_COUNT_BITS) begin : g_sat
      assign s2_item_next.count[i] =
        (|raw[fmsds_pkg::RAW_WIDTH-1:fmsds_pkg::STEP_COUNT_BITS]) ? '1
                                    : raw[fmsds_pkg::STEP_COUNT_BITS-1:0];
    end else begin : g_fit
      assign s2_item_next.count[i] = fmsds_pkg::STEP_COUNT_BITS'(raw);
    end
  end

  // Count register
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= adv1 || (s2_valid && !adv2);
    end
  end

  always_ff @(posedge clk) begin
    if (adv1) begin
      s2_item <= s2_item_next;
    end
  end

  // Sequencer: state update and result register
  fmsds_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .apply  (adv2),
    .item   (s2_item),
    .status (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= adv2 || (out_valid && out_stall);
    end
  end

  assign step_level      = status.step_level;
  assign direction_up    = status.direction_up;
  assign shared_enable   = status.shared_enable;
  assign busy_res        = status.busy;
  assign command_ignored = status.ignored;

  for (genvar i = 0; i < fmsds_pkg::ENABLE_OUT_BITS; i++) begin : g_en
    if (i < fmsds_pkg::MOTOR_COUNT) begin : g_motor
      assign motor_enables[i] = status.motor_enables[i];
    end else begin : g_none
      assign motor_enables[i] = 1'b0;
    end
  end

  // Checks
  `FMSDS_ASSERT(a_idle_released, clk, rst, !busy_res |-> (motor_enables == '0 && shared_enable))
  `FMSDS_ASSERT(a_busy_holds_enable, clk, rst, busy_res |-> !shared_enable)
  `FMSDS_ASSERT(a_ignored_busy, clk, rst, command_ignored |-> busy_res)
  `FMSDS_ASSERT(a_pulse_busy, clk, rst, step_level |-> busy_res)

endmodule

`default_nettype wire

/* sim/four_motor_split_direction_stepper_tb.sv */
// Self-checking testbench for the four-motor split-direction stepper sequencer.
`timescale 1ns / 100ps

module four_motor_split_direction_stepper_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS = 10;
  // Random moves aim for at most this many steps per motor
  localparam int TARGET_STEPS = 6;

  typedef logic [fmsds_pkg::DEV_FIELDS-1:0][fmsds_pkg::DEV_WIDTH-1:0] dev_set_t;

  typedef struct packed {
    logic     op;
    dev_set_t dev;
  } move_cmd_t;

  typedef enum logic [1:0] {
    MOVE_IDLE = 2'd0,
    MOVE_UP   = 2'd1,
    MOVE_DOWN = 2'd2
  } move_phase_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                                   cfg_write_enable = 1'b0;
  logic [fmsds_pkg::SPM_WIDTH-1:0]        cfg_write_data = '0;
  logic                                   in_valid = 1'b0;
  logic                                   in_stall;
  logic                                   operation = fmsds_pkg::OP_TICK;
  logic signed [fmsds_pkg::DEV_WIDTH-1:0] deviation_a = '0;
  logic signed [fmsds_pkg::DEV_WIDTH-1:0] deviation_b = '0;
  logic signed [fmsds_pkg::DEV_WIDTH-1:0] deviation_c = '0;
  logic signed [fmsds_pkg::DEV_WIDTH-1:0] deviation_d = '0;
  logic                                   out_valid;
  logic                                   out_stall = 1'b0;
  logic                                   step_level;
  logic                                   direction_up;
  logic [fmsds_pkg::ENABLE_OUT_BITS-1:0]  motor_enables;
  logic                                   shared_enable;
  logic                                   busy_res;
  logic                                   command_ignored;

  four_motor_split_direction_stepper dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_write_data   (cfg_write_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .operation        (operation),
    .deviation_a      (deviation_a),
    .deviation_b      (deviation_b),
    .deviation_c      (deviation_c),
    .deviation_d      (deviation_d),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .step_level       (step_level),
    .direction_up     (direction_up),
    .motor_enables    (motor_enables),
    .shared_enable    (shared_enable),
    .busy_res         (busy_res),
    .command_ignored  (command_ignored)
  );

  always #5 clk = ~clk;

  // Stimulus and expected status traffic
  move_cmd_t              cmd_queue[$];
  fmsds_pkg::seq_status_t status_due[$];
  int                     send_idle_pct = 0;
  int                     recv_idle_pct = 0;
  int                     mismatches = 0;
  int                     results_checked = 0;
  int                     cycles = 0;
  int                     settings_used = 0;

  // Sequencer model state
  logic [fmsds_pkg::SPM_WIDTH-1:0]   spm_model = fmsds_pkg::SPM_RESET;
  fmsds_pkg::count_t                 steps_total[fmsds_pkg::MOTOR_COUNT];
  logic [fmsds_pkg::MOTOR_COUNT-1:0] goes_up = '0;
  move_phase_t                       phase = MOVE_IDLE;
  int unsigned                       step_idx = 0;
  int unsigned                       group_len = 0;
  logic                              pulse = 1'b0;
  logic [fmsds_pkg::MOTOR_COUNT-1:0] en_mask = '0;
  logic                              common_en = 1'b1;
  logic                              dir_line = 1'b0;
  int                                moves_run = 0;
  int                                starts_dropped = 0;
  int                                ticks_seen = 0;

  initial begin
    for (int i = 0; i < fmsds_pkg::MOTOR_COUNT; i++) steps_total[i] = '0;
  end

  // Rounded |dev| * step rate with 24 fraction bits dropped, saturated
  function automatic fmsds_pkg::count_t step_count(logic [fmsds_pkg::DEV_WIDTH-1:0] dev,
                                                   logic [fmsds_pkg::SPM_WIDTH-1:0] spm);
    logic [fmsds_pkg::DEV_WIDTH-1:0] mag;
    logic [40:0]                     prod;
    logic [40:0]                     raw;
    mag  = dev[fmsds_pkg::DEV_WIDTH-1] ? (~dev + 1'b1) : dev;
    prod = 41'(mag) * 41'(spm) + (41'd1 << 23);
    raw  = prod >> 24;
    if (raw > 41'({fmsds_pkg::STEP_COUNT_BITS{1'b1}})) return '1;
    return fmsds_pkg::count_t'(raw);
  endfunction

  function automatic logic moves_up(logic [fmsds_pkg::DEV_WIDTH-1:0] dev);
    return !dev[fmsds_pkg::DEV_WIDTH-1] && (dev != '0);
  endfunction

  function automatic int unsigned open_group(logic up);
    int unsigned                       longest;
    logic [fmsds_pkg::MOTOR_COUNT-1:0] mask;
    longest = 0;
    mask = '0;
    for (int i = 0; i < fmsds_pkg::MOTOR_COUNT; i++) begin
      if (goes_up[i] == up && steps_total[i] != '0) begin
        mask[i] = 1'b1;
        if (steps_total[i] > longest) longest = steps_total[i];
      end
    end
    if (longest != 0) begin
      en_mask = mask;
      group_len = longest;
      step_idx = 0;
      pulse = 1'b0;
      dir_line = up;
      phase = up ? MOVE_UP : MOVE_DOWN;
    end
    return longest;
  endfunction

  function automatic void close_move();
    en_mask = '0;
    pulse = 1'b0;
    step_idx = 0;
    group_len = 0;
    common_en = 1'b1;
    phase = MOVE_IDLE;
  endfunction

  function automatic void begin_move(dev_set_t dev);
    logic any_steps;
    any_steps = 1'b0;
    for (int i = 0; i < fmsds_pkg::MOTOR_COUNT; i++) begin
      steps_total[i] = (i < fmsds_pkg::DEV_FIELDS) ? step_count(dev[i], spm_model) : '0;
      goes_up[i] = (i < fmsds_pkg::DEV_FIELDS) ? moves_up(dev[i]) : 1'b0;
      if (steps_total[i] != '0) any_steps = 1'b1;
    end
    if (!any_steps) return;
    moves_run++;
    common_en = 1'b0;
    if (open_group(1'b1) == 0) begin
      if (open_group(1'b0) == 0) close_move();
    end
  endfunction

  // One half step period
  function automatic void half_step();
    if (phase != MOVE_UP && phase != MOVE_DOWN) return;
    if (!pulse) begin
      for (int i = 0; i < fmsds_pkg::MOTOR_COUNT; i++)
        if (steps_total[i] == step_idx) en_mask[i] = 1'b0;
      pulse = 1'b1;
      return;
    end
    pulse = 1'b0;
    step_idx++;
    if (step_idx < group_len) return;
    en_mask = '0;
    if (phase == MOVE_UP && open_group(1'b0) != 0) return;
    close_move();
  endfunction

  // Advances the model by one command and returns the status it should produce
  function automatic fmsds_pkg::seq_status_t sequencer_status(move_cmd_t cmd);
    logic dropped;
    logic moving;
    dropped = 1'b0;
    moving = (phase == MOVE_UP || phase == MOVE_DOWN);
    if (cmd.op == fmsds_pkg::OP_START) begin
      if (moving) begin
        dropped = 1'b1;
        starts_dropped++;
      end else begin
        begin_move(cmd.dev);
      end
    end else begin
      ticks_seen++;
      half_step();
    end
    moving = (phase == MOVE_UP || phase == MOVE_DOWN);
    return '{step_level: pulse, direction_up: dir_line, motor_enables: en_mask,
             shared_enable: common_en, busy: moving, ignored: dropped};
  endfunction

  // Driver: predicts each accepted beat, then offers the next pending command
  always @(posedge clk) begin : cmd_driver
    move_cmd_t nxt;
    move_cmd_t sent;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sent.op = operation;
        sent.dev = {deviation_d, deviation_c, deviation_b, deviation_a};
        status_due.push_back(sequencer_status(sent));
      end
      if (!in_valid || !in_stall) begin
        if (cmd_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = cmd_queue.pop_front();
          operation   <= nxt.op;
          deviation_a <= nxt.dev[0];
          deviation_b <= nxt.dev[1];
          deviation_c <= nxt.dev[2];
          deviation_d <= nxt.dev[3];
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each status beat against the oldest prediction
  always @(posedge clk) begin : status_monitor
    fmsds_pkg::seq_status_t got;
    fmsds_pkg::seq_status_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = '{step_level: step_level, direction_up: direction_up,
                motor_enables: motor_enables, shared_enable: shared_enable,
                busy: busy_res, ignored: command_ignored};
        if (status_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("status beat with nothing pending: %p", got);
        end else begin
          want = status_due.pop_front();
          results_checked++;
          if (got.step_level !== want.step_level || got.direction_up !== want.direction_up ||
              got.motor_enables !== want.motor_enables ||
              got.shared_enable !== want.shared_enable ||
              got.busy !== want.busy || got.ignored !== want.ignored) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display(
                "beat %0d: step %b/%b dir %b/%b en %b/%b sh %b/%b busy %b/%b drop %b/%b exp/got",
                results_checked, want.step_level, got.step_level,
                want.direction_up, got.direction_up,
                want.motor_enables, got.motor_enables,
                want.shared_enable, got.shared_enable,
                want.busy, got.busy, want.ignored, got.ignored);
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d status beats outstanding",
               cycles, status_due.size());
      $display("[four_motor_split_direction_stepper] ERROR");
      $finish;
    end
  end

  task automatic queue_start(logic [fmsds_pkg::DEV_WIDTH-1:0] a,
                             logic [fmsds_pkg::DEV_WIDTH-1:0] b,
                             logic [fmsds_pkg::DEV_WIDTH-1:0] c,
                             logic [fmsds_pkg::DEV_WIDTH-1:0] d);
    cmd_queue.push_back('{op: fmsds_pkg::OP_START, dev: {d, c, b, a}});
  endtask

  task automatic queue_ticks(int n);
    for (int i = 0; i < n; i++) cmd_queue.push_back('{op: fmsds_pkg::OP_TICK, dev: '0});
  endtask

  // Waits until every command went out and every status came back
  task automatic wait_quiet();
    do @(negedge clk);
    while (cmd_queue.size() != 0 || in_valid || status_due.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_step_rate(logic [fmsds_pkg::SPM_WIDTH-1:0] value);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_write_data   <= value;
    @(posedge clk);
    cfg_write_enable <= 1'b0;
    spm_model = value;
    settings_used++;
    @(negedge clk);
  endtask

  // Magnitude that keeps counts near TARGET_STEPS at the current rate
  function automatic logic [fmsds_pkg::DEV_WIDTH-1:0] random_dev();
    longint                          bound;
    int unsigned                     mag;
    logic [fmsds_pkg::DEV_WIDTH-1:0] d;
    bound = (spm_model == '0) ? 524288 : (longint'(TARGET_STEPS) << 24) / spm_model;
    if (bound > 524288) bound = 524288;
    if ($urandom_range(0, 7) == 0) return '0;
    mag = $urandom_range(0, int'(bound));
    d = fmsds_pkg::DEV_WIDTH'(mag);
    if ($urandom_range(0, 1)) d = ~d + 1'b1;
    else if (mag > 524287) d = fmsds_pkg::DEV_WIDTH'(524287);
    return d;
  endfunction

  // One start followed by the ticks that complete it, with some noise mixed in
  task automatic queue_random_move(inout int planned);
    dev_set_t    d;
    int unsigned up_len;
    int unsigned down_len;
    int unsigned cnt;
    int unsigned ticks;
    up_len = 0;
    down_len = 0;
    for (int i = 0; i < fmsds_pkg::DEV_FIELDS; i++) begin
      d[i] = random_dev();
      cnt = step_count(d[i], spm_model);
      if (moves_up(d[i])) begin
        if (cnt > up_len) up_len = cnt;
      end else if (cnt > down_len) begin
        down_len = cnt;
      end
    end
    queue_start(d[0], d[1], d[2], d[3]);
    planned++;
    ticks = 2 * (up_len + down_len);
    // cut short now and then; the next start may then land on a busy sequencer
    if ($urandom_range(0, 9) == 0) ticks = $urandom_range(0, ticks);
    for (int t = 0; t < ticks; t++) begin
      if ($urandom_range(0, 24) == 0)
        queue_start(random_dev(), random_dev(), random_dev(), random_dev());
      queue_ticks(1);
      planned++;
    end
    if ($urandom_range(0, 4) == 0) queue_ticks($urandom_range(1, 2));
  endtask

  task automatic run_random(int n, logic pause_midway);
    int planned;
    planned = 0;
    while (planned < n) begin
      queue_random_move(planned);
      wait (cmd_queue.size() < 64);
      @(negedge clk);
      // hold the sender back until everything in flight has drained
      if (pause_midway && planned >= n / 2) begin
        wait_quiet();
        pause_midway = 1'b0;
      end
    end
  endtask

  initial begin
    send_idle_pct = 20;
    recv_idle_pct = 73;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part at 0.25 steps/mm: one step per 4 mm, half a step at 2 mm
    write_step_rate(fmsds_pkg::SPM_WIDTH'(64));
    queue_ticks(1);                                     // tick while idle
    queue_start('0, '0, '0, '0);                        // all zero
    queue_start(20'sd131071, -20'sd131071, '0, '0);     // just below half a step
    // both groups, half-step rounding up, both field extremes
    queue_start(20'sd131072, -20'sd262144, 20'sd524287, -20'sd524288);
    queue_ticks(2);
    queue_start(20'sd262144, '0, '0, '0);               // start while busy
    queue_ticks(6);
    queue_ticks(1);                                     // idle, direction holds low
    queue_start(-20'sd131072, '0, '0, '0);              // downward group only
    queue_ticks(2);
    queue_start(20'sd262144, 20'sd262144, 20'sd262144, 20'sd262144);
    queue_ticks(2);
    wait_quiet();

    write_step_rate(fmsds_pkg::SPM_RESET);
    run_random(500, 1'b1);
    wait_quiet();

    send_idle_pct = 73;
    recv_idle_pct = 20;
    write_step_rate({fmsds_pkg::SPM_WIDTH{1'b1}});
    run_random(450, 1'b0);
    wait_quiet();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_step_rate('0);
    run_random(40, 1'b0);
    wait_quiet();

    for (int k = 0; k < 2; k++) begin
      write_step_rate(fmsds_pkg::SPM_WIDTH'($urandom_range(1, 1048575)));
      run_random(230, 1'b0);
      wait_quiet();
    end

    if (status_due.size() != 0) mismatches++;
    $display("covered %0d moves, %0d dropped starts and %0d ticks over %0d step rates",
             moves_run, starts_dropped, ticks_seen, settings_used);
    $display("%0d status beats checked, %0d mismatches", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("[four_motor_split_direction_stepper] OK");
    end else begin
      $display("[four_motor_split_direction_stepper] ERROR");
    end
    $finish;
  end

endmodule
